### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the core's sequencer (acs_ctrl).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// check a property on every rising edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check that an expression never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### sv/acs_pkg.sv
// ----------------------------------------------------------------------------
// acs_pkg
// Types, opcodes and sizes shared by the accumulator stack core.
// ----------------------------------------------------------------------------
package acs_pkg;

  localparam int unsigned MEM_WORDS = 65536;
  localparam int unsigned MEM_AW    = $clog2(MEM_WORDS);

  localparam logic [31:0] STEP_LIMIT_RESET = 32'd100000;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_EXEC  = 2'd2,
    OP_NONE  = 2'd3
  } item_op_t;

  localparam logic [7:0] OPC_LDC  = 8'd0;
  localparam logic [7:0] OPC_ADC  = 8'd1;
  localparam logic [7:0] OPC_LDL  = 8'd2;
  localparam logic [7:0] OPC_STL  = 8'd3;
  localparam logic [7:0] OPC_LDNL = 8'd4;
  localparam logic [7:0] OPC_STNL = 8'd5;
  localparam logic [7:0] OPC_ADD  = 8'd6;
  localparam logic [7:0] OPC_SUB  = 8'd7;
  localparam logic [7:0] OPC_SHL  = 8'd8;
  localparam logic [7:0] OPC_SHR  = 8'd9;
  localparam logic [7:0] OPC_ADJ  = 8'd10;
  localparam logic [7:0] OPC_A2SP = 8'd11;
  localparam logic [7:0] OPC_SP2A = 8'd12;
  localparam logic [7:0] OPC_CALL = 8'd13;
  localparam logic [7:0] OPC_RET  = 8'd14;
  localparam logic [7:0] OPC_BRZ  = 8'd15;
  localparam logic [7:0] OPC_BRLZ = 8'd16;
  localparam logic [7:0] OPC_BR   = 8'd17;
  localparam logic [7:0] OPC_HALT = 8'd18;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic fetch;
    logic exec;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic stopped;
  } ctrl_sts_t;

endpackage

### sv/acs_in_if.sv
// ----------------------------------------------------------------------------
// acs_in_if
// Input word channel: memory write, memory read or execute request.
// ----------------------------------------------------------------------------
interface acs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic [15:0]        address;
  logic signed [31:0] write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

### sv/acs_out_if.sv
// ----------------------------------------------------------------------------
// acs_out_if
// Result word channel: read data and architectural state after each item.
// ----------------------------------------------------------------------------
interface acs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_data;
  logic signed [31:0] pc_value;
  logic signed [31:0] a_value;
  logic signed [31:0] b_value;
  logic signed [31:0] sp_value;
  logic [7:0]         executed_opcode;
  logic signed [23:0] executed_operand;
  logic               halted;
  logic               limit_hit;

  modport source (
    output valid, output read_data, output pc_value, output a_value, output b_value,
    output sp_value, output executed_opcode, output executed_operand, output halted,
    output limit_hit, input ready
  );
  modport sink (
    input valid, input read_data, input pc_value, input a_value, input b_value,
    input sp_value, input executed_opcode, input executed_operand, input halted,
    input limit_hit, output ready
  );
endinterface

### sv/acs_ctrl.sv
// ----------------------------------------------------------------------------
// acs_ctrl
// Sequencer: memory clear after reset, item accept, fetch, execute, result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module acs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  acs_pkg::item_op_t   in_op,
  output logic                in_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  acs_pkg::ctrl_sts_t  sts,
  output acs_pkg::ctrl_cmd_t  cmd
);
  import acs_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_EXEC  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.clear_wr = (state_r == ST_CLEAR);
    cmd.accept   = (state_r == ST_IDLE) && in_valid;
    cmd.fetch    = (state_r == ST_FETCH);
    cmd.exec     = (state_r == ST_EXEC);
    cmd.finish   = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_EXEC && !sts.stopped) state_nxt = ST_FETCH;
          else                                  state_nxt = ST_DONE;
        end
      end
      ST_FETCH: state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (cmd.finish) state_nxt = ST_IDLE;
      end
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    priority if (cmd.finish) out_valid_nxt = 1'b1;
    else if (out_ready)      out_valid_nxt = 1'b0;
    else                     out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_PROP(a_exec_to_fetch, clk, rst_n, (cmd.accept && in_op == OP_EXEC && !sts.stopped) |=> cmd.fetch, "execute word skipped fetch")
  `ASSERT_PROP(a_fetch_then_exec, clk, rst_n, cmd.fetch |=> cmd.exec, "fetch not followed by execute")
  `ASSERT_NEVER(a_finish_busy, clk, rst_n, cmd.finish && out_valid_r && !out_ready, "result overwritten while waiting")
  `ASSERT_NEVER(a_clear_accept, clk, rst_n, cmd.clear_wr && in_ready, "word accepted during memory clear")

endmodule

### sv/acs_datapath.sv
// ----------------------------------------------------------------------------
// acs_datapath
// Word memory, architectural registers, execute unit and result register.
// ----------------------------------------------------------------------------
module acs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  acs_pkg::ctrl_cmd_t  cmd,
  output acs_pkg::ctrl_sts_t  sts,
  input  acs_pkg::item_op_t   in_op,
  input  logic [15:0]         in_address,
  input  logic [31:0]         in_write_data,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  output logic [31:0]         out_read_data,
  output logic [31:0]         out_pc_value,
  output logic [31:0]         out_a_value,
  output logic [31:0]         out_b_value,
  output logic [31:0]         out_sp_value,
  output logic [7:0]          out_executed_opcode,
  output logic [23:0]         out_executed_operand,
  output logic                out_halted,
  output logic                out_limit_hit
);
  import acs_pkg::*;

  logic [31:0]        mem [MEM_WORDS];
  logic [31:0]        mem_q_r;
  logic               mem_we, mem_re;
  logic [MEM_AW-1:0]  mem_addr;
  logic [31:0]        mem_wd;
  logic [MEM_AW-1:0]  clr_addr_r;

  logic [31:0] a_r, b_r, pc_r, sp_r, cnt_r, step_limit_r, ir_r;
  logic        halt_r, limit_r, exec_rep_r;
  item_op_t    item_op_r;

  logic [31:0] a_nxt, b_nxt, pc_nxt, sp_nxt, cnt_nxt;
  logic        halt_nxt, limit_nxt;

  logic [31:0] item_addr32, f_opd, f_ea_sp, f_ea_a;
  logic [7:0]  f_opc, x_opc;
  logic [31:0] x_opd, pc1, pc_br, shl_v, shr_v, cnt_inc;

  assign sts.clear_last = &clr_addr_r;
  assign sts.stopped    = halt_r | limit_r;

  assign item_addr32 = {16'd0, in_address};
  assign f_opc       = mem_q_r[7:0];
  assign f_opd       = {{8{mem_q_r[31]}}, mem_q_r[31:8]};
  assign f_ea_sp     = sp_r + f_opd;
  assign f_ea_a      = a_r + f_opd;

  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = item_addr32[MEM_AW-1:0];
    mem_wd   = in_write_data;
    priority if (cmd.clear_wr) begin
      mem_we   = 1'b1;
      mem_addr = clr_addr_r;
      mem_wd   = '0;
    end else if (cmd.accept) begin
      unique case (in_op)
        OP_WRITE: mem_we = 1'b1;
        OP_READ:  mem_re = 1'b1;
        OP_EXEC: begin
          mem_re   = !sts.stopped;
          mem_addr = pc_r[MEM_AW-1:0];
        end
        default:  mem_re = 1'b0;
      endcase
    end else if (cmd.fetch) begin
      unique case (f_opc)
        OPC_LDL: begin
          mem_re   = 1'b1;
          mem_addr = f_ea_sp[MEM_AW-1:0];
        end
        OPC_STL: begin
          mem_we   = 1'b1;
          mem_addr = f_ea_sp[MEM_AW-1:0];
          mem_wd   = a_r;
        end
        OPC_LDNL: begin
          mem_re   = 1'b1;
          mem_addr = f_ea_a[MEM_AW-1:0];
        end
        OPC_STNL: begin
          mem_we   = 1'b1;
          mem_addr = f_ea_a[MEM_AW-1:0];
          mem_wd   = b_r;
        end
        default: mem_re = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wd;
    if (mem_re) mem_q_r <= mem[mem_addr];
  end

  // execute stage: instruction in ir_r, load data in mem_q_r
  assign x_opc   = ir_r[7:0];
  assign x_opd   = {{8{ir_r[31]}}, ir_r[31:8]};
  assign pc1     = pc_r + 32'd1;
  assign pc_br   = pc1 + x_opd;
  assign shl_v   = (a_r > 32'd31) ? 32'd0 : (b_r << a_r[4:0]);
  assign shr_v   = (a_r > 32'd31) ? {32{b_r[31]}} : $unsigned($signed(b_r) >>> a_r[4:0]);
  assign cnt_inc = (&cnt_r) ? cnt_r : cnt_r + 32'd1;

  always_comb begin
    a_nxt     = a_r;
    b_nxt     = b_r;
    pc_nxt    = pc1;
    sp_nxt    = sp_r;
    halt_nxt  = halt_r;
    cnt_nxt   = cnt_inc;
    unique case (x_opc)
      OPC_LDC:  begin b_nxt = a_r; a_nxt = x_opd; end
      OPC_ADC:  a_nxt = a_r + x_opd;
      OPC_LDL:  begin b_nxt = a_r; a_nxt = mem_q_r; end
      OPC_STL:  a_nxt = b_r;
      OPC_LDNL: a_nxt = mem_q_r;
      OPC_STNL: a_nxt = a_r;
      OPC_ADD:  a_nxt = b_r + a_r;
      OPC_SUB:  a_nxt = b_r - a_r;
      OPC_SHL:  a_nxt = shl_v;
      OPC_SHR:  a_nxt = shr_v;
      OPC_ADJ:  sp_nxt = sp_r + x_opd;
      OPC_A2SP: begin sp_nxt = a_r; a_nxt = b_r; end
      OPC_SP2A: begin b_nxt = a_r; a_nxt = sp_r; end
      OPC_CALL: begin b_nxt = a_r; a_nxt = pc1; pc_nxt = pc_br; end
      OPC_RET:  begin pc_nxt = a_r; a_nxt = b_r; end
      OPC_BRZ:  if (a_r == 32'd0) pc_nxt = pc_br;
      OPC_BRLZ: if (a_r[31]) pc_nxt = pc_br;
      OPC_BR:   pc_nxt = pc_br;
      OPC_HALT: begin halt_nxt = 1'b1; cnt_nxt = cnt_r; end
      default:  a_nxt = a_r;
    endcase
    limit_nxt = limit_r | ((x_opc != OPC_HALT) && (cnt_inc > step_limit_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r   <= '0;
      a_r          <= '0;
      b_r          <= '0;
      pc_r         <= '0;
      sp_r         <= '0;
      cnt_r        <= '0;
      halt_r       <= 1'b0;
      limit_r      <= 1'b0;
      exec_rep_r   <= 1'b0;
      item_op_r    <= OP_NONE;
      step_limit_r <= STEP_LIMIT_RESET;
    end else begin
      if (cfg_we)       step_limit_r <= cfg_wdata;
      if (cmd.clear_wr) clr_addr_r <= clr_addr_r + MEM_AW'(1);
      if (cmd.accept) begin
        item_op_r  <= in_op;
        exec_rep_r <= 1'b0;
      end
      if (cmd.fetch) begin
        exec_rep_r <= 1'b1;
      end
      if (cmd.exec) begin
        a_r     <= a_nxt;
        b_r     <= b_nxt;
        pc_r    <= pc_nxt;
        sp_r    <= sp_nxt;
        cnt_r   <= cnt_nxt;
        halt_r  <= halt_nxt;
        limit_r <= limit_nxt;
      end
    end
  end

  // payload registers: no reset
  always_ff @(posedge clk) begin
    if (cmd.fetch) ir_r <= mem_q_r;
    if (cmd.finish) begin
      out_read_data        <= (item_op_r == OP_READ) ? mem_q_r : 32'd0;
      out_pc_value         <= pc_r;
      out_a_value          <= a_r;
      out_b_value          <= b_r;
      out_sp_value         <= sp_r;
      out_executed_opcode  <= exec_rep_r ? ir_r[7:0] : 8'd0;
      out_executed_operand <= exec_rep_r ? ir_r[31:8] : 24'd0;
      out_halted           <= halt_r;
      out_limit_hit        <= limit_r;
    end
  end

endmodule

### sv/accumulator_stack_cpu_core_top.sv
// ----------------------------------------------------------------------------
// accumulator_stack_cpu_core_top
// Two-register accumulator/stack core with a 32-bit word memory.
// ----------------------------------------------------------------------------
// After reset the core zeroes all MEM_WORDS (65536) words of its word
// memory, one word a cycle, and takes no input word until this pass ends;
// step-limit writes are taken throughout. A memory write, a memory read or
// an execute request on a stopped core then goes from accept to result;
// an executed instruction goes through accept with instruction fetch,
// data access, writeback and result. The single-port word memory carries
// one access per cycle and sets that sequence. The result register holds
// one word; the next input word is accepted while it waits to be taken.
module accumulator_stack_cpu_core_top (
  input  logic        clk,
  input  logic        rst_n,
  acs_in_if.sink      in_if,
  acs_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import acs_pkg::*;

  ctrl_cmd_t   cmd;
  ctrl_sts_t   sts;
  item_op_t    in_op;
  logic [31:0] read_data, pc_value, a_value, b_value, sp_value;
  logic [23:0] executed_operand;

  assign in_op = item_op_t'(in_if.op);

  acs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_op     (in_op),
    .in_ready  (in_if.ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  acs_datapath u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_op                (in_op),
    .in_address           (in_if.address),
    .in_write_data        ($unsigned(in_if.write_data)),
    .cfg_we               (cfg_we),
    .cfg_wdata            (cfg_wdata),
    .out_read_data        (read_data),
    .out_pc_value         (pc_value),
    .out_a_value          (a_value),
    .out_b_value          (b_value),
    .out_sp_value         (sp_value),
    .out_executed_opcode  (out_if.executed_opcode),
    .out_executed_operand (executed_operand),
    .out_halted           (out_if.halted),
    .out_limit_hit        (out_if.limit_hit)
  );

  assign out_if.read_data        = $signed(read_data);
  assign out_if.pc_value         = $signed(pc_value);
  assign out_if.a_value          = $signed(a_value);
  assign out_if.b_value          = $signed(b_value);
  assign out_if.sp_value         = $signed(sp_value);
  assign out_if.executed_operand = $signed(executed_operand);

endmodule
